/* src/fcc_lattice_neighbor_generator_core_defines.svh */
// Assertion macros shared by the lattice neighbor generator RTL.
`ifndef FCC_LATTICE_NEIGHBOR_GENERATOR_CORE_DEFINES_SVH
`define FCC_LATTICE_NEIGHBOR_GENERATOR_CORE_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define FCCLNG_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define FCCLNG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/fcclng_pkg.sv */
// Types, constants and the offset table of the lattice neighbor generator.
package fcclng_pkg;

   localparam int SITE_W        = 17;
   localparam int CELL_W        = SITE_W - 2;
   localparam int CFG_W         = 6;
   localparam int OFFSET_W      = 5;
   localparam int OFFSET_COUNT  = 27;
   localparam int NEAREST_COUNT = 6;
   localparam int STEP_W        = 3;
   localparam int DATA_W        = 24;

   localparam logic [OFFSET_W-1:0] LAST_OFFSET   = OFFSET_W'(OFFSET_COUNT - 1);
   localparam logic [OFFSET_W-1:0] FIRST_FURTHER = OFFSET_W'(NEAREST_COUNT);

   typedef struct packed {
      logic signed [STEP_W-1:0] dx;
      logic signed [STEP_W-1:0] dy;
      logic signed [STEP_W-1:0] dz;
   } fcclng_step_type;

   typedef struct packed {
      logic                relation;
      logic [OFFSET_W-1:0] offset_number;
      logic                last;
   } fcclng_tag_type;

   typedef struct packed {
      logic [SITE_W-1:0]   neighbor_index;
      logic                relation;
      logic [OFFSET_W-1:0] offset_number;
      logic                present;
      logic                last;
   } fcclng_result_type;

   function automatic fcclng_step_type make_step(input int x, input int y, input int z);
      fcclng_step_type s;
      s.dx = STEP_W'(x);
      s.dy = STEP_W'(y);
      s.dz = STEP_W'(z);
      return s;
   endfunction

   // Forward nearest offsets first, then the further shells, in doubled units.
   function automatic fcclng_step_type offset_step(input logic [OFFSET_W-1:0] k);
      fcclng_step_type s;
      unique case (k)
         5'd0:    s = make_step( 1,  1,  0);
         5'd1:    s = make_step( 1, -1,  0);
         5'd2:    s = make_step( 1,  0,  1);
         5'd3:    s = make_step( 1,  0, -1);
         5'd4:    s = make_step( 0,  1,  1);
         5'd5:    s = make_step( 0,  1, -1);
         5'd6:    s = make_step( 2,  2,  0);
         5'd7:    s = make_step( 2,  0,  0);
         5'd8:    s = make_step( 0,  2,  0);
         5'd9:    s = make_step( 2,  1,  1);
         5'd10:   s = make_step( 2,  1, -1);
         5'd11:   s = make_step( 1,  2,  1);
         5'd12:   s = make_step( 1,  2, -1);
         5'd13:   s = make_step( 2, -2,  0);
         5'd14:   s = make_step( 2, -1,  1);
         5'd15:   s = make_step( 2, -1, -1);
         5'd16:   s = make_step( 1, -2, -1);
         5'd17:   s = make_step( 1, -2,  1);
         5'd18:   s = make_step( 2,  0,  2);
         5'd19:   s = make_step( 0,  0,  2);
         5'd20:   s = make_step( 1,  1,  2);
         5'd21:   s = make_step( 1, -1,  2);
         5'd22:   s = make_step( 2,  0, -2);
         5'd23:   s = make_step( 1, -1, -2);
         5'd24:   s = make_step( 1,  1, -2);
         5'd25:   s = make_step( 0,  2,  2);
         5'd26:   s = make_step( 0,  2, -2);
         default: s = make_step( 0,  0,  0);
      endcase
      return s;
   endfunction

endpackage

/* src/fcclng_decode.sv */
// Pipelined decode of a site index into doubled lattice coordinates.
module fcclng_decode
   import fcclng_pkg::*;
#(
   parameter int CW  = 5,
   parameter int M_W = 6
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [SITE_W-1:0]    in_site,
   input  logic [M_W-1:0]       m_eff,
   input  logic [2*M_W-1:0]     m2,
   input  logic [3*M_W-1:0]     m3,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [CW:0]          out_bx,
   output logic [CW:0]          out_by,
   output logic [CW:0]          out_bz,
   output logic                 out_in_range
);

   localparam int NSTG  = 2 * CW;
   localparam int DIV_W = CELL_W + 2 * M_W + CW;
   localparam int TOT_W = 3 * M_W + 2;
   localparam int CMP_W = (SITE_W > TOT_W) ? SITE_W : TOT_W;

   logic              vld_ff  [0:NSTG];
   logic [CELL_W-1:0] rem_ff  [0:NSTG];
   logic [CW-1:0]     zq_ff   [0:NSTG];
   logic [CW-1:0]     yq_ff   [0:NSTG];
   logic [1:0]        sub_ff  [0:NSTG];
   logic [SITE_W-1:0] site_ff [0:NSTG];
   logic              rdy     [0:NSTG+1];

   logic              out_vld_ff;
   logic [CW:0]       bx_ff;
   logic [CW:0]       by_ff;
   logic [CW:0]       bz_ff;
   logic              range_ff;
   logic              range_in;

   assign rdy[NSTG+1] = !out_vld_ff || out_ready;

   for (genvar j = 0; j <= NSTG; j++) begin : g_rdy
      assign rdy[j] = !vld_ff[j] || rdy[j+1];
   end

   assign in_ready = rdy[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (rdy[0]) begin
         vld_ff[0] <= in_valid;
      end
      if (rdy[0]) begin
         rem_ff[0]  <= in_site[SITE_W-1:2];
         sub_ff[0]  <= in_site[1:0];
         site_ff[0] <= in_site;
         zq_ff[0]   <= '0;
         yq_ff[0]   <= '0;
      end
   end

   // Restoring division: first the layer index by m squared, then the row by m.
   for (genvar j = 1; j <= NSTG; j++) begin : g_step
      localparam int SH   = CW - 1 - ((j - 1) % CW);
      localparam bit IS_Z = (j - 1) < CW;

      logic [DIV_W-1:0]  rem_ext;
      logic [DIV_W-1:0]  trial;
      logic              take;
      logic [CELL_W-1:0] rem_in;
      logic [CW-1:0]     zq_in;
      logic [CW-1:0]     yq_in;

      always_comb begin
         rem_ext = DIV_W'(rem_ff[j-1]);
         trial   = (IS_Z ? DIV_W'(m2) : DIV_W'(m_eff)) << SH;
         take    = rem_ext >= trial;
         rem_in  = take ? CELL_W'(rem_ext - trial) : rem_ff[j-1];
         zq_in   = zq_ff[j-1];
         yq_in   = yq_ff[j-1];
         if (IS_Z) begin
            zq_in[SH] = take;
         end else begin
            yq_in[SH] = take;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else if (rdy[j]) begin
            vld_ff[j] <= vld_ff[j-1];
         end
         if (rdy[j]) begin
            rem_ff[j]  <= rem_in;
            sub_ff[j]  <= sub_ff[j-1];
            site_ff[j] <= site_ff[j-1];
            zq_ff[j]   <= zq_in;
            yq_ff[j]   <= yq_in;
         end
      end
   end

   assign range_in = CMP_W'(site_ff[NSTG]) < CMP_W'({m3, 2'b00});

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (rdy[NSTG+1]) begin
         out_vld_ff <= vld_ff[NSTG];
      end
      if (rdy[NSTG+1]) begin
         bx_ff    <= {rem_ff[NSTG][CW-1:0], ^sub_ff[NSTG]};
         by_ff    <= {yq_ff[NSTG], sub_ff[NSTG][0]};
         bz_ff    <= {zq_ff[NSTG], sub_ff[NSTG][1]};
         range_ff <= range_in;
      end
   end

   assign out_valid    = out_vld_ff;
   assign out_bx       = bx_ff;
   assign out_by       = by_ff;
   assign out_bz       = bz_ff;
   assign out_in_range = range_ff;

endmodule

/* src/fcclng_expand.sv */
// Sequencer that walks one decoded site through the fixed offset list.
module fcclng_expand
   import fcclng_pkg::*;
#(
   parameter int CW = 5
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            base_valid,
   output logic            base_ready,
   input  logic [CW:0]     base_bx,
   input  logic [CW:0]     base_by,
   input  logic [CW:0]     base_bz,
   input  logic            base_in_range,
   output logic            emit_valid,
   input  logic            emit_ready,
   output logic [CW:0]     emit_bx,
   output logic [CW:0]     emit_by,
   output logic [CW:0]     emit_bz,
   output logic            emit_in_range,
   output fcclng_step_type emit_step,
   output fcclng_tag_type  emit_tag
);

   logic                busy_ff;
   logic                busy_in;
   logic [OFFSET_W-1:0] k_ff;
   logic [OFFSET_W-1:0] k_in;
   logic [CW:0]         bx_ff;
   logic [CW:0]         by_ff;
   logic [CW:0]         bz_ff;
   logic                range_ff;
   logic                fire;
   logic                at_end;
   logic                load;

   assign fire       = busy_ff && emit_ready;
   assign at_end     = k_ff == LAST_OFFSET;
   assign base_ready = !busy_ff || (fire && at_end);
   assign load       = base_valid && base_ready;

   always_comb begin
      busy_in = busy_ff;
      k_in    = k_ff;
      if (load) begin
         busy_in = 1'b1;
         k_in    = '0;
      end else if (fire) begin
         if (at_end) begin
            busy_in = 1'b0;
         end else begin
            k_in = k_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         k_ff    <= '0;
      end else begin
         busy_ff <= busy_in;
         k_ff    <= k_in;
      end
      if (load) begin
         bx_ff    <= base_bx;
         by_ff    <= base_by;
         bz_ff    <= base_bz;
         range_ff <= base_in_range;
      end
   end

   assign emit_valid             = busy_ff;
   assign emit_bx                = bx_ff;
   assign emit_by                = by_ff;
   assign emit_bz                = bz_ff;
   assign emit_in_range          = range_ff;
   assign emit_step              = offset_step(k_ff);
   assign emit_tag.relation      = k_ff >= FIRST_FURTHER;
   assign emit_tag.offset_number = k_ff;
   assign emit_tag.last          = at_end;

endmodule

/* src/fcclng_locate.sv */
// Three-stage pipeline that turns a shifted position into a neighbor site index.
module fcclng_locate
   import fcclng_pkg::*;
#(
   parameter int CW  = 5,
   parameter int M_W = 6
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [CW:0]       in_bx,
   input  logic [CW:0]       in_by,
   input  logic [CW:0]       in_bz,
   input  logic              in_in_range,
   input  fcclng_step_type   in_step,
   input  fcclng_tag_type    in_tag,
   input  logic [M_W-1:0]    m_eff,
   input  logic [2*M_W-1:0]  m2,
   output logic              out_valid,
   input  logic              out_ready,
   output fcclng_result_type out_result
);

   localparam int DW     = CW + 1;
   localparam int PW     = DW + 2;
   localparam int LIM_W  = M_W + 1;
   localparam int BW     = (PW > LIM_W) ? PW : LIM_W;
   localparam int PY_W   = CW + M_W;
   localparam int PZ_W   = CW + 2 * M_W;
   localparam int SUM_W  = CW + 2 * M_W + 1;
   localparam int NI_W   = SUM_W + 2;
   localparam int WIDE_W = (NI_W > SITE_W) ? NI_W : SITE_W;

   logic signed [PW-1:0] px;
   logic signed [PW-1:0] py;
   logic signed [PW-1:0] pz;
   logic [BW-1:0]        lim;
   logic                 here_in;

   logic                 v1_ff;
   logic [CW-1:0]        cx1_ff;
   logic [CW-1:0]        cy1_ff;
   logic [CW-1:0]        cz1_ff;
   logic [1:0]           sub1_ff;
   logic                 here1_ff;
   fcclng_tag_type       tag1_ff;

   logic                 v2_ff;
   logic [CW-1:0]        cx2_ff;
   logic [PY_W-1:0]      py2_ff;
   logic [PZ_W-1:0]      pz2_ff;
   logic [1:0]           sub2_ff;
   logic                 here2_ff;
   fcclng_tag_type       tag2_ff;

   logic                 v3_ff;
   fcclng_result_type    result_ff;
   logic [SUM_W-1:0]     sum_in;
   logic [WIDE_W-1:0]    wide_in;
   logic [SITE_W-1:0]    index_in;

   logic                 r1;
   logic                 r2;
   logic                 r3;

   assign r3       = !v3_ff || out_ready;
   assign r2       = !v2_ff || r3;
   assign r1       = !v1_ff || r2;
   assign in_ready = r1;

   always_comb begin
      px  = $signed({2'b00, in_bx}) + PW'(in_step.dx);
      py  = $signed({2'b00, in_by}) + PW'(in_step.dy);
      pz  = $signed({2'b00, in_bz}) + PW'(in_step.dz);
      lim = BW'({m_eff, 1'b0});
      here_in = in_in_range
         && !px[PW-1] && (BW'(px[PW-2:0]) < lim)
         && !py[PW-1] && (BW'(py[PW-2:0]) < lim)
         && !pz[PW-1] && (BW'(pz[PW-2:0]) < lim);
   end

   always_comb begin
      sum_in   = SUM_W'(cx2_ff) + SUM_W'(py2_ff) + SUM_W'(pz2_ff);
      wide_in  = WIDE_W'({sum_in, sub2_ff});
      index_in = here2_ff ? wide_in[SITE_W-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (r1) begin
            v1_ff <= in_valid;
         end
         if (r2) begin
            v2_ff <= v1_ff;
         end
         if (r3) begin
            v3_ff <= v2_ff;
         end
      end
      if (r1) begin
         cx1_ff   <= px[CW:1];
         cy1_ff   <= py[CW:1];
         cz1_ff   <= pz[CW:1];
         sub1_ff  <= {pz[0], py[0]};
         here1_ff <= here_in;
         tag1_ff  <= in_tag;
      end
      if (r2) begin
         cx2_ff   <= cx1_ff;
         py2_ff   <= PY_W'(cy1_ff) * PY_W'(m_eff);
         pz2_ff   <= PZ_W'(cz1_ff) * PZ_W'(m2);
         sub2_ff  <= sub1_ff;
         here2_ff <= here1_ff;
         tag2_ff  <= tag1_ff;
      end
      if (r3) begin
         result_ff.neighbor_index <= index_in;
         result_ff.relation       <= tag2_ff.relation;
         result_ff.offset_number  <= tag2_ff.offset_number;
         result_ff.present        <= here2_ff;
         result_ff.last           <= tag2_ff.last;
      end
   end

   assign out_valid  = v3_ff;
   assign out_result = result_ff;

endmodule

/* src/fcc_lattice_neighbor_generator_core.sv */
// Top level of the face-centered cubic lattice neighbor generator.
//
//   Channel  Direction  Transfer                   Contents
//   req      in         req_tvalid && req_tready   site index
//   rsp      out        rsp_tvalid && rsp_tready   neighbor index, offset, flags
//   csr      in         csr_wr_en                  cells per edge
//
// Each site yields 27 results, one per cycle while rsp_tready stays high; the offset
// sequencer takes the next site only as it emits the last result of the current one.
// The decode divider holds 2*log2(MAX_CELLS_PER_EDGE) + 2 stages, the sequencer one
// and the locate stages 3.
// Reset is synchronous and clears all valid bits; cells per edge returns to 1.
// A low rsp_tready holds every occupied stage in place and backs up to req_tready.
`include "fcc_lattice_neighbor_generator_core_defines.svh"

module fcc_lattice_neighbor_generator_core
   import fcclng_pkg::*;
#(
   parameter int MAX_CELLS_PER_EDGE = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [DATA_W-1:0] req_tdata,   // site_index, zero fill
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [DATA_W-1:0] rsp_tdata,   // neighbor_index, offset_number, present, zero fill
   output logic              rsp_tuser,   // relation
   output logic              rsp_tlast,
   input  logic              csr_wr_en,
   input  logic [CFG_W-1:0]  csr_wr_data
);

   localparam int CW   = (MAX_CELLS_PER_EDGE > 1) ? $clog2(MAX_CELLS_PER_EDGE) : 1;
   localparam int M_W  = $clog2(MAX_CELLS_PER_EDGE + 1);
   localparam int M2_W = 2 * M_W;
   localparam int M3_W = 3 * M_W;
   localparam int EW   = (CFG_W > M_W) ? CFG_W : M_W;

   logic [CFG_W-1:0]  cells_ff;
   logic [EW-1:0]     cells_ext;
   logic [M_W-1:0]    m_eff;
   logic [M2_W-1:0]   m2_ff;
   logic [M3_W-1:0]   m3_ff;

   logic              dec_valid;
   logic              dec_ready;
   logic [CW:0]       dec_bx;
   logic [CW:0]       dec_by;
   logic [CW:0]       dec_bz;
   logic              dec_in_range;

   logic              emit_valid;
   logic              emit_ready;
   logic [CW:0]       emit_bx;
   logic [CW:0]       emit_by;
   logic [CW:0]       emit_bz;
   logic              emit_in_range;
   fcclng_step_type   emit_step;
   fcclng_tag_type    emit_tag;

   fcclng_result_type result;
   logic              rsp_fire;

   always_comb begin
      cells_ext = EW'(cells_ff);
      if (cells_ext == '0) begin
         m_eff = M_W'(1);
      end else if (cells_ext > EW'(MAX_CELLS_PER_EDGE)) begin
         m_eff = M_W'(MAX_CELLS_PER_EDGE);
      end else begin
         m_eff = M_W'(cells_ext);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cells_ff <= CFG_W'(1);
         m2_ff    <= M2_W'(1);
         m3_ff    <= M3_W'(1);
      end else begin
         if (csr_wr_en) begin
            cells_ff <= csr_wr_data;
         end
         m2_ff <= M2_W'(m_eff) * M2_W'(m_eff);
         m3_ff <= M3_W'(m2_ff) * M3_W'(m_eff);
      end
   end

   fcclng_decode #(
      .CW  (CW),
      .M_W (M_W)
   ) u_decode (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .in_site      (req_tdata[SITE_W-1:0]),
      .m_eff        (m_eff),
      .m2           (m2_ff),
      .m3           (m3_ff),
      .out_valid    (dec_valid),
      .out_ready    (dec_ready),
      .out_bx       (dec_bx),
      .out_by       (dec_by),
      .out_bz       (dec_bz),
      .out_in_range (dec_in_range)
   );

   fcclng_expand #(
      .CW (CW)
   ) u_expand (
      .clock         (clock),
      .reset         (reset),
      .base_valid    (dec_valid),
      .base_ready    (dec_ready),
      .base_bx       (dec_bx),
      .base_by       (dec_by),
      .base_bz       (dec_bz),
      .base_in_range (dec_in_range),
      .emit_valid    (emit_valid),
      .emit_ready    (emit_ready),
      .emit_bx       (emit_bx),
      .emit_by       (emit_by),
      .emit_bz       (emit_bz),
      .emit_in_range (emit_in_range),
      .emit_step     (emit_step),
      .emit_tag      (emit_tag)
   );

   fcclng_locate #(
      .CW  (CW),
      .M_W (M_W)
   ) u_locate (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (emit_valid),
      .in_ready    (emit_ready),
      .in_bx       (emit_bx),
      .in_by       (emit_by),
      .in_bz       (emit_bz),
      .in_in_range (emit_in_range),
      .in_step     (emit_step),
      .in_tag      (emit_tag),
      .m_eff       (m_eff),
      .m2          (m2_ff),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_result  (result)
   );

   assign rsp_tdata = DATA_W'({result.present, result.offset_number, result.neighbor_index});
   assign rsp_tuser = result.relation;
   assign rsp_tlast = result.last;
   assign rsp_fire  = rsp_tvalid && rsp_tready;

   `FCCLNG_ASSERT_NOW(a_last_on_final_offset, clock, reset, rsp_tvalid,
      result.last == (result.offset_number == LAST_OFFSET),
      "last flag does not match the final offset")
   `FCCLNG_ASSERT_NOW(a_relation_by_offset, clock, reset, rsp_tvalid,
      result.relation == (result.offset_number >= FIRST_FURTHER),
      "relation does not match the offset number")
   `FCCLNG_ASSERT_NOW(a_absent_reads_zero, clock, reset, rsp_tvalid && !result.present,
      result.neighbor_index == '0,
      "absent neighbor carries a nonzero index")
   `FCCLNG_ASSERT_NEXT(a_offsets_in_order, clock, reset, rsp_fire && !result.last,
      !rsp_tvalid || (result.offset_number == $past(result.offset_number) + 5'd1),
      "offsets of one site are out of order")

endmodule

/* test/fcclng_checker.sv */
// Checker for the lattice neighbor generator: predicts and compares the results of each site.
module fcclng_checker
   import fcclng_pkg::*;
#(
   parameter int MAX_CELLS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_tready,
   input  logic [DATA_W-1:0] req_tdata,
   input  logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  logic [DATA_W-1:0] rsp_tdata,
   input  logic              rsp_tuser,
   input  logic              rsp_tlast,
   input  logic              csr_wr_en,
   input  logic [CFG_W-1:0]  csr_wr_data,
   output int                fail_count,
   output int                expected_left,
   output int                results_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      fcclng_result_type  res;
      logic [SITE_W-1:0]  site;
   } neighbor_expect_type;

   int step_x [OFFSET_COUNT] = '{1, 1, 1, 1, 0, 0, 2, 2, 0, 2, 2, 1, 1, 2,
                                 2, 2, 1, 1, 2, 0, 1, 1, 2, 1, 1, 0, 0};
   int step_y [OFFSET_COUNT] = '{1, -1, 0, 0, 1, 1, 2, 0, 2, 1, 1, 2, 2, -2,
                                 -1, -1, -2, -2, 0, 0, 1, -1, 0, -1, 1, 2, 2};
   int step_z [OFFSET_COUNT] = '{0, 0, 1, -1, 1, -1, 0, 0, 0, 1, -1, 1, -1, 0,
                                 1, -1, -1, 1, 2, 2, 2, 2, -2, -2, -2, 2, -2};

   neighbor_expect_type neighbor_queue [$];
   logic [CFG_W-1:0]    cells_reg;
   int                  mismatches = 0;
   int                  checked = 0;

   assign fail_count   = mismatches;
   assign results_seen = checked;

   task automatic report_mismatch(input string msg);
      if (mismatches < 40) begin
         $display("checker: %s", msg);
      end
      mismatches++;
   endtask

   function automatic void predict_neighbors(input logic [SITE_W-1:0] site,
                                             input logic [CFG_W-1:0] cells);
      int                  m, total, cell_num, sub, bx, by, bz, px, py, pz, lim, idx;
      bit                  in_range, here;
      neighbor_expect_type e;
      m = (cells == 0) ? 1 : ((int'(cells) > MAX_CELLS) ? MAX_CELLS : int'(cells));
      total = 4 * m * m * m;
      in_range = int'(site) < total;
      bx = 0;
      by = 0;
      bz = 0;
      if (in_range) begin
         cell_num = int'(site) / 4;
         sub = int'(site) % 4;
         bx = 2 * ((cell_num % (m * m)) % m);
         by = 2 * ((cell_num % (m * m)) / m);
         bz = 2 * (cell_num / (m * m));
         if (sub == 1) begin
            bx++;
            by++;
         end else if (sub == 2) begin
            bx++;
            bz++;
         end else if (sub == 3) begin
            by++;
            bz++;
         end
      end
      lim = 2 * m;
      for (int k = 0; k < OFFSET_COUNT; k++) begin
         px = bx + step_x[k];
         py = by + step_y[k];
         pz = bz + step_z[k];
         here = in_range && px >= 0 && px < lim && py >= 0 && py < lim && pz >= 0 && pz < lim;
         idx = 0;
         if (here) begin
            idx = 4 * ((px / 2) + (py / 2) * m + (pz / 2) * m * m);
            if (pz % 2 == 1) begin
               idx += (py % 2 == 1) ? 3 : 2;
            end else begin
               idx += (py % 2 == 1) ? 1 : 0;
            end
         end
         e.site = site;
         e.res.neighbor_index = SITE_W'(idx);
         e.res.relation = (k >= NEAREST_COUNT);
         e.res.offset_number = OFFSET_W'(k);
         e.res.present = here;
         e.res.last = (k == OFFSET_COUNT - 1);
         neighbor_queue.push_back(e);
      end
   endfunction

   task automatic check_neighbor(input fcclng_result_type got);
      neighbor_expect_type e;
      if (neighbor_queue.size() == 0) begin
         report_mismatch($sformatf("result with nothing expected, neighbor_index %0d offset %0d",
                                   got.neighbor_index, got.offset_number));
      end else begin
         e = neighbor_queue.pop_front();
         if (got.neighbor_index !== e.res.neighbor_index)
            report_mismatch($sformatf("site %0d offset %0d: neighbor_index %0d, expected %0d",
                            e.site, e.res.offset_number, got.neighbor_index,
                            e.res.neighbor_index));
         if (got.relation !== e.res.relation)
            report_mismatch($sformatf("site %0d offset %0d: relation %b, expected %b",
                            e.site, e.res.offset_number, got.relation, e.res.relation));
         if (got.offset_number !== e.res.offset_number)
            report_mismatch($sformatf("site %0d: offset_number %0d, expected %0d",
                            e.site, got.offset_number, e.res.offset_number));
         if (got.present !== e.res.present)
            report_mismatch($sformatf("site %0d offset %0d: present %b, expected %b",
                            e.site, e.res.offset_number, got.present, e.res.present));
         if (got.last !== e.res.last)
            report_mismatch($sformatf("site %0d offset %0d: last %b, expected %b",
                            e.site, e.res.offset_number, got.last, e.res.last));
      end
      checked++;
   endtask

   always @(posedge clock) begin
      fcclng_result_type got;
      if (reset) begin
         cells_reg = CFG_W'(1);
         neighbor_queue.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            predict_neighbors(req_tdata[SITE_W-1:0], cells_reg);
         end
         if (csr_wr_en) begin
            cells_reg = csr_wr_data;
         end
         if (rsp_tvalid === 1'b1 && rsp_tready) begin
            got.neighbor_index = rsp_tdata[SITE_W-1:0];
            got.offset_number = rsp_tdata[SITE_W +: OFFSET_W];
            got.present = rsp_tdata[SITE_W + OFFSET_W];
            got.relation = rsp_tuser;
            got.last = rsp_tlast;
            check_neighbor(got);
         end
      end
      expected_left <= neighbor_queue.size();
   end

endmodule

/* test/tb.sv */
// Testbench top for the lattice neighbor generator: clock, reset, stimulus and verdict.
module tb
   import fcclng_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_CELLS  = 32;
   localparam int IDLE_LIMIT = 2000;
   localparam int DRAIN_WAIT = 40;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [DATA_W-1:0] req_tdata = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [DATA_W-1:0] rsp_tdata;
   logic              rsp_tuser;
   logic              rsp_tlast;
   logic              csr_wr_en = 1'b0;
   logic [CFG_W-1:0]  csr_wr_data = '0;

   int fail_count;
   int expected_left;
   int results_seen;
   int idle_pct = 0;
   int stall_pct = 0;
   int idle_cycles = 0;
   int sites_sent = 0;
   int sizes_used = 1;
   int cur_edge = 1;

   fcc_lattice_neighbor_generator_core #(
      .MAX_CELLS_PER_EDGE(MAX_CELLS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   fcclng_checker #(
      .MAX_CELLS(MAX_CELLS)
   ) checker_i (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .fail_count(fail_count),
      .expected_left(expected_left),
      .results_seen(results_seen)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Timeout: no transfer for %0d cycles.", IDLE_LIMIT);
         $display("tb NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic set_idling(input int mode);
      case (mode)
         0: begin
            idle_pct = 0;
            stall_pct = 0;
         end
         1: begin
            idle_pct = 82;
            stall_pct = 0;
         end
         2: begin
            idle_pct = 0;
            stall_pct = 82;
         end
         default: begin
            idle_pct = 18;
            stall_pct = 18;
         end
      endcase
   endtask

   task automatic send_site(input logic [SITE_W-1:0] site);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= DATA_W'(site);
      do @(posedge clock); while (!req_tready);
      sites_sent++;
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_left != 0);
   endtask

   task automatic write_cells(input logic [CFG_W-1:0] value);
      drain_results();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cur_edge = (value == 0) ? 1 : ((int'(value) > MAX_CELLS) ? MAX_CELLS : int'(value));
      sizes_used++;
   endtask

   function automatic logic [SITE_W-1:0] random_site();
      int total;
      total = 4 * cur_edge * cur_edge * cur_edge;
      if ($urandom_range(99) < 85) begin
         return SITE_W'($urandom_range(total - 1));
      end
      return SITE_W'($urandom);
   endfunction

   initial begin
      int edge_list [10] = '{2, 4, 32, 1, 5, 63, 17, 0, 9, 32};
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // One cell per edge after reset: every sub-site, the first site outside, all ones.
      for (int s = 0; s < 5; s++) send_site(SITE_W'(s));
      send_site('1);
      write_cells(CFG_W'(3));
      for (int s = 0; s < 4; s++) send_site(SITE_W'(s));
      for (int s = 52; s < 56; s++) send_site(SITE_W'(s));
      send_site(SITE_W'(107));
      send_site(SITE_W'(108));
      send_site('1);
      write_cells(CFG_W'(0));
      send_site(SITE_W'(0));
      send_site(SITE_W'(3));
      send_site(SITE_W'(4));
      write_cells('1);
      send_site(SITE_W'(0));
      send_site(SITE_W'(65536));
      send_site('1);

      for (int p = 0; p < 10; p++) begin
         write_cells(CFG_W'(edge_list[p]));
         set_idling(p % 4);
         for (int i = 0; i < 26; i++) begin
            if (p == 3 && i == 13) drain_results();
            send_site(random_site());
         end
      end

      drain_results();
      repeat (DRAIN_WAIT) @(posedge clock);
      $display("Sent %0d sites and checked %0d neighbor results across %0d edge settings,",
               sites_sent, results_seen, sizes_used);
      $display("including out-of-range sites, clamped sizes, and sender gaps and receiver stalls.");
      if (fail_count == 0 && expected_left == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+src
src/fcclng_pkg.sv
src/fcclng_decode.sv
src/fcclng_expand.sv
src/fcclng_locate.sv
src/fcc_lattice_neighbor_generator_core.sv
test/fcclng_checker.sv
test/tb.sv
